// File: rtl/srg_pkg.sv
// ---------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and helpers for the SURF random generator.
// ---------------------------------------------------------------------------
package srg_pkg;

   typedef logic [31:0] word_type;
   typedef logic [1:0]  cmd_type;
   typedef logic [4:0]  index_type;

   localparam int SEED_WORDS = 32;
   localparam int CTR_WORDS  = 12;
   localparam int MIX_WORDS  = 12;
   localparam int OUT_WORDS  = 8;
   localparam int ROUNDS     = 16;

   // seed slices: key words, counter whitening words, output start words
   localparam int SEED_CTR_BASE = 12;
   localparam int SEED_OUT_BASE = 24;
   // mixing words folded into the output after each pass
   localparam int MIX_OUT_BASE  = 4;

   localparam word_type GOLDEN_STEP = 32'h9E37_79B9;

   localparam cmd_type CMD_LOAD_SEED = 2'd0;
   localparam cmd_type CMD_LOAD_CTR  = 2'd1;
   localparam cmd_type CMD_GENERATE  = 2'd2;

   // rotate left by 5, 7, 9, 13 in turn
   function automatic word_type rotl_step(word_type v, logic [1:0] sel);
      word_type r;
      case (sel)
         2'd0:    r = {v[26:0], v[31:27]};
         2'd1:    r = {v[24:0], v[31:25]};
         2'd2:    r = {v[22:0], v[31:23]};
         default: r = {v[18:0], v[31:19]};
      endcase
      return r;
   endfunction

endpackage

// File: rtl/srg_req_if.sv
// ---------------------------------------------------------------------------
// srg_req_if
// Request channel: command, word index and load value.
// ---------------------------------------------------------------------------
interface srg_req_if
   import srg_pkg::*;
();
   logic      valid;
   logic      ready;
   cmd_type   cmd;
   index_type word_index;
   word_type  word_value;

   modport source (output valid, output cmd, output word_index, output word_value,
                   input ready);
   modport sink   (input valid, input cmd, input word_index, input word_value,
                   output ready);
endinterface

// File: rtl/srg_rsp_if.sv
// ---------------------------------------------------------------------------
// srg_rsp_if
// Response channel: one generated word and its last flag.
// ---------------------------------------------------------------------------
interface srg_rsp_if
   import srg_pkg::*;
();
   logic     valid;
   logic     ready;
   word_type out_word;
   logic     word_last;

   modport source (output valid, output out_word, output word_last, input ready);
   modport sink   (input valid, input out_word, input word_last, output ready);
endinterface

// File: rtl/surf_random_generator_unit.sv
// ---------------------------------------------------------------------------
// surf_random_generator_unit
// SURF keyed random generator with a single shared add-xor-rotate unit.
// ---------------------------------------------------------------------------
// Load transactions (seed word, counter word) leave the block ready and
// give no response; a counter load with an index above 11 is dropped. A
// generate transaction whitens the counter with the seed, then runs the
// mixing unit once per step for 2 passes x 16 rounds x 12 steps,
// each step depending on the chain value of the one before. A fold state
// follows each pass, then the eight words leave one per response
// transaction, the last one flagged. The block takes no request until the
// eighth word has gone.
// ---------------------------------------------------------------------------
module surf_random_generator_unit
   import srg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   srg_req_if.sink   req,
   srg_rsp_if.source rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_FOLD = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic [3:0] STEP_LAST  = 4'(MIX_WORDS - 1);
   localparam logic [3:0] ROUND_LAST = 4'(ROUNDS - 1);
   localparam logic [2:0] OUT_LAST   = 3'(OUT_WORDS - 1);

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [3:0] round_ff, round_in;
   logic       pass_ff, pass_in;
   logic [2:0] ocnt_ff, ocnt_in;

   word_type seed_ff [SEED_WORDS];
   word_type seed_in [SEED_WORDS];
   word_type ctr_ff  [CTR_WORDS];
   word_type ctr_in  [CTR_WORDS];
   word_type mix_ff  [MIX_WORDS];
   word_type mix_in  [MIX_WORDS];
   word_type out_ff  [OUT_WORDS];
   word_type out_in  [OUT_WORDS];
   word_type chain_ff, chain_in;
   word_type sum_ff, sum_in;

   logic     req_fire, rsp_fire;
   word_type step_a, step_b, step_new;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = (state_ff == ST_OUT);
   assign rsp.out_word  = out_ff[0];
   assign rsp.word_last = (ocnt_ff == OUT_LAST);

   // shared mixing unit: head of the mixing line is the word being updated
   assign step_a   = (chain_ff ^ seed_ff[{1'b0, step_ff}]) + sum_ff;
   assign step_b   = rotl_step(chain_ff, step_ff[1:0]);
   assign step_new = mix_ff[0] + (step_a ^ step_b);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      round_in = round_ff;
      pass_in  = pass_ff;
      ocnt_in  = ocnt_ff;
      seed_in  = seed_ff;
      ctr_in   = ctr_ff;
      mix_in   = mix_ff;
      out_in   = out_ff;
      chain_in = chain_ff;
      sum_in   = sum_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.cmd)
                  CMD_LOAD_SEED: seed_in[req.word_index] = req.word_value;
                  CMD_LOAD_CTR: begin
                     if (req.word_index < 5'(CTR_WORDS))
                        ctr_in[req.word_index[3:0]] = req.word_value;
                  end
                  CMD_GENERATE: begin
                     for (int i = 0; i < MIX_WORDS; i++)
                        mix_in[i] = ctr_ff[i] ^ seed_ff[SEED_CTR_BASE + i];
                     for (int i = 0; i < OUT_WORDS; i++)
                        out_in[i] = seed_ff[SEED_OUT_BASE + i];
                     chain_in = ctr_ff[MIX_WORDS-1] ^ seed_ff[SEED_CTR_BASE + MIX_WORDS - 1];
                     // sum already advanced for the first round
                     sum_in   = GOLDEN_STEP;
                     step_in  = '0;
                     round_in = '0;
                     pass_in  = 1'b0;
                     state_in = ST_MIX;
                  end
                  default: ;
               endcase
            end
         end

         ST_MIX: begin
            for (int i = 0; i < MIX_WORDS - 1; i++)
               mix_in[i] = mix_ff[i+1];
            mix_in[MIX_WORDS-1] = step_new;
            chain_in = step_new;
            if (step_ff == STEP_LAST) begin
               step_in = '0;
               sum_in  = sum_ff + GOLDEN_STEP;
               if (round_ff == ROUND_LAST) begin
                  round_in = '0;
                  state_in = ST_FOLD;
               end else begin
                  round_in = round_ff + 4'd1;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end

         ST_FOLD: begin
            for (int i = 0; i < OUT_WORDS; i++)
               out_in[i] = out_ff[i] ^ mix_ff[MIX_OUT_BASE + i];
            if (pass_ff) begin
               ctr_in[0]  = ctr_ff[0] + 32'd1;
               ctr_in[5]  = ctr_ff[5] + 32'd1;
               ctr_in[11] = ctr_ff[11] + 32'd1;
               ocnt_in    = '0;
               state_in   = ST_OUT;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_MIX;
            end
         end

         ST_OUT: begin
            if (rsp_fire) begin
               for (int i = 0; i < OUT_WORDS - 1; i++)
                  out_in[i] = out_ff[i+1];
               ocnt_in = ocnt_ff + 3'd1;
               if (ocnt_ff == OUT_LAST)
                  state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         round_ff <= '0;
         pass_ff  <= 1'b0;
         ocnt_ff  <= '0;
         for (int i = 0; i < SEED_WORDS; i++)
            seed_ff[i] <= '0;
         for (int i = 0; i < CTR_WORDS; i++)
            ctr_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         round_ff <= round_in;
         pass_ff  <= pass_in;
         ocnt_ff  <= ocnt_in;
         seed_ff  <= seed_in;
         ctr_ff   <= ctr_in;
      end
   end

   // working words are always rebuilt at the start of a generate
   always_ff @(posedge clock) begin
      mix_ff   <= mix_in;
      out_ff   <= out_in;
      chain_ff <= chain_in;
      sum_ff   <= sum_in;
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("request accepted while responses pending");

   a_gen_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.cmd == CMD_GENERATE)
      |=> (state_ff == ST_MIX && step_ff == 4'd0 && round_ff == 4'd0 && !pass_ff))
      else $error("generate did not start a clean mixing run");

   a_load_stays_ready: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.cmd != CMD_GENERATE) |=> req.ready)
      else $error("load transaction left the block busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp.word_last) |=> (req.ready && !rsp.valid))
      else $error("block not free after last word");

   a_step_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && step_ff == STEP_LAST) |=> (step_ff == 4'd0))
      else $error("step counter did not wrap after a round");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the SURF random generator. A scoreboard keeps its
// own copy of the seed and counter, recomputes the eight words of every
// generate and compares each response transaction in order. Directed loads
// and generates come first, then random rekey sequences with noise, with
// random idling on both channels and one long response hold-off.
// ---------------------------------------------------------------------------
import srg_pkg::*;

class srg_scoreboard;
   word_type seed_words[SEED_WORDS];
   word_type ctr_words[CTR_WORDS];
   word_type expected_words[$];
   logic     expected_last[$];
   int       mismatches;

   function new();
      foreach (seed_words[i]) seed_words[i] = '0;
      foreach (ctr_words[i]) ctr_words[i] = '0;
      mismatches = 0;
   endfunction

   // update key/counter copies; a generate queues its eight words
   function void note_request(cmd_type c, index_type idx, word_type v);
      word_type    mix[MIX_WORDS];
      word_type    outw[OUT_WORDS];
      word_type    chain;
      word_type    sum;
      word_type    a;
      word_type    b;
      int unsigned rot_by[4] = '{5, 7, 9, 13};
      int unsigned rot;
      if (c == CMD_LOAD_SEED) begin
         seed_words[idx] = v;
      end else if (c == CMD_LOAD_CTR) begin
         if (idx < CTR_WORDS) ctr_words[idx] = v;
      end else if (c == CMD_GENERATE) begin
         for (int i = 0; i < MIX_WORDS; i++)
            mix[i] = ctr_words[i] ^ seed_words[SEED_CTR_BASE + i];
         for (int i = 0; i < OUT_WORDS; i++)
            outw[i] = seed_words[SEED_OUT_BASE + i];
         chain = mix[MIX_WORDS - 1];
         sum   = '0;
         for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < ROUNDS; r++) begin
               sum += GOLDEN_STEP;
               for (int i = 0; i < MIX_WORDS; i++) begin
                  rot    = rot_by[i % 4];
                  a      = (chain ^ seed_words[i]) + sum;
                  b      = (chain << rot) | (chain >> (32 - rot));
                  mix[i] = mix[i] + (a ^ b);
                  chain  = mix[i];
               end
            end
            for (int i = 0; i < OUT_WORDS; i++)
               outw[i] ^= mix[i + MIX_OUT_BASE];
         end
         ctr_words[0]  += 1;
         ctr_words[5]  += 1;
         ctr_words[11] += 1;
         for (int k = 0; k < OUT_WORDS; k++) begin
            expected_words.push_back(outw[k]);
            expected_last.push_back(k == OUT_WORDS - 1);
         end
      end
   endfunction

   function void check_response(word_type w, logic l);
      word_type ew;
      logic     el;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: word %h last %b", w, l);
      end else begin
         ew = expected_words.pop_front();
         el = expected_last.pop_front();
         if (w !== ew || l !== el) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected %h/%b, got %h/%b", ew, el, w, l);
         end
      end
   endfunction
endclass

module testbench;
   localparam cmd_type CMD_UNUSED     = 2'd3;
   localparam int      TOTAL_ITEMS    = 270;
   localparam int      HOLD_CYCLES    = 1200;
   localparam int      WATCHDOG_LIMIT = 6000;
   localparam int      DRAIN_CYCLES   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srg_req_if req ();
   srg_rsp_if rsp ();

   surf_random_generator_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   srg_scoreboard sb = new();
   int items_sent     = 0;
   bit send_steady    = 1'b0;
   int stalled_cycles = 0;

   always #10 clock = ~clock;

   function automatic word_type pick_value();
      word_type v;
      case ($urandom_range(9))
         0:       v = '0;
         1:       v = '1;
         2:       v = 32'h8000_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_request(cmd_type c, index_type idx, word_type v);
      while (!send_steady && $urandom_range(99) < 28) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.cmd        <= c;
      req.word_index <= idx;
      req.word_value <= v;
      do @(posedge clock); while (!req.ready);
      sb.note_request(c, idx, v);
      items_sent++;
   endtask

   // response side: random back-pressure plus one long hold mid-generate
   initial begin
      int taken;
      bit held;
      taken      = 0;
      held       = 1'b0;
      rsp.ready  = 1'b0;
      forever begin
         rsp.ready <= (taken >= 120 && taken < 200) || ($urandom_range(99) >= 28);
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            sb.check_response(rsp.out_word, rsp.word_last);
            taken++;
            if (!held && taken >= 20 && !rsp.word_last) begin
               held = 1'b1;
               rsp.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("[surf_random_generator_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int loads;
      req.valid      = 1'b0;
      req.cmd        = CMD_LOAD_SEED;
      req.word_index = '0;
      req.word_value = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all-zero key and counter straight after reset
      send_request(CMD_GENERATE, 5'd0, 32'h0);
      send_request(CMD_LOAD_SEED, 5'd0, 32'hFFFF_FFFF);
      send_request(CMD_LOAD_SEED, 5'd31, 32'hFFFF_FFFF);
      send_request(CMD_LOAD_SEED, 5'd12, 32'h8000_0000);
      send_request(CMD_LOAD_SEED, 5'd24, 32'h0000_0001);
      // counter words that wrap on the next increment
      send_request(CMD_LOAD_CTR, 5'd0, 32'hFFFF_FFFF);
      send_request(CMD_LOAD_CTR, 5'd5, 32'hFFFF_FFFF);
      send_request(CMD_LOAD_CTR, 5'd11, 32'hFFFF_FFFF);
      // out-of-range counter writes and the spare command must do nothing
      send_request(CMD_LOAD_CTR, 5'd12, 32'hFFFF_FFFF);
      send_request(CMD_LOAD_CTR, 5'd31, 32'h5A5A_5A5A);
      send_request(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
      send_request(CMD_GENERATE, 5'd31, 32'hFFFF_FFFF);
      send_request(CMD_GENERATE, 5'd0, 32'h0);
      send_request(CMD_LOAD_SEED, 5'd23, 32'h0);
      send_request(CMD_LOAD_CTR, 5'd11, 32'h0);
      send_request(CMD_GENERATE, 5'd7, 32'h1234_5678);

      while (items_sent < TOTAL_ITEMS) begin
         send_steady = items_sent >= 120 && items_sent < 180;
         kind = $urandom_range(99);
         if (kind < 55) begin
            loads = $urandom_range(1, 6);
            repeat (loads) begin
               if ($urandom_range(1))
                  send_request(CMD_LOAD_SEED,
                               index_type'($urandom_range(SEED_WORDS - 1)), pick_value());
               else
                  send_request(CMD_LOAD_CTR,
                               index_type'($urandom_range(CTR_WORDS - 1)), pick_value());
            end
            send_request(CMD_GENERATE, index_type'($urandom_range(31)), $urandom);
         end else if (kind < 80) begin
            send_request(CMD_GENERATE, index_type'($urandom_range(31)), $urandom);
         end else begin
            case ($urandom_range(2))
               0:       send_request(CMD_LOAD_CTR,
                                     index_type'($urandom_range(CTR_WORDS, 31)), $urandom);
               1:       send_request(CMD_UNUSED, index_type'($urandom_range(31)), $urandom);
               default: send_request(CMD_LOAD_SEED,
                                     index_type'($urandom_range(31)), pick_value());
            endcase
         end
      end
      req.valid <= 1'b0;

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("[surf_random_generator_unit] OK");
      else
         $display("[surf_random_generator_unit] ERROR");
      $finish;
   end
endmodule

// File: sim.f
rtl/srg_pkg.sv
rtl/srg_req_if.sv
rtl/srg_rsp_if.sv
rtl/surf_random_generator_unit.sv
tb/testbench.sv
